// ===== sv/heartbeat_watchdog_power_cycler_macros.svh =====
// ----------------------------------------------------------------------------
// heartbeat watchdog power cycler - assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_WATCHDOG_POWER_CYCLER_MACROS_SVH
`define HEARTBEAT_WATCHDOG_POWER_CYCLER_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HBW_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define HBW_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/hbw_pkg.sv =====
// ----------------------------------------------------------------------------
// hbw_pkg
// shared types and constants of the heartbeat watchdog power cycler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hbw_pkg;

    // event kinds
    typedef enum logic [1:0] {
        REQ_TICK      = 2'd0,
        REQ_HEARTBEAT = 2'd1,
        REQ_SUPPLY    = 2'd2
    } req_type_t;

    // restart sequence phases
    typedef enum logic [1:0] {
        PH_IDLE       = 2'd0,
        PH_MAIN_OFF   = 2'd1,
        PH_MODULE_OFF = 2'd2
    } phase_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE_SECONDS   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MISS_LIMIT       = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_MAIN_OFF_TICKS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_MODULE_OFF_TICKS = 3'd3;

    localparam logic [7:0] SETTLE_SECONDS_RST   = 8'd60;
    localparam logic [7:0] MISS_LIMIT_RST       = 8'd5;
    localparam logic [7:0] MAIN_OFF_TICKS_RST   = 8'd3;
    localparam logic [7:0] MODULE_OFF_TICKS_RST = 8'd3;

    typedef struct packed {
        logic [7:0] settle_seconds;
        logic [7:0] miss_limit;
        logic [7:0] main_off_ticks;
        logic [7:0] module_off_ticks;
    } cfg_t;

    typedef struct packed {
        logic main_power_on;
        logic module_enable;
        logic restart_active;
        logic supply_lost;
    } result_t;

endpackage

// ===== sv/hbw_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// hbw_cfg_regs
// configuration register file, write only
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hbw_cfg_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [hbw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hbw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output hbw_pkg::cfg_t                      cfg
);

    hbw_pkg::cfg_t cfg_reg;
    hbw_pkg::cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hbw_pkg::REG_SETTLE_SECONDS:   cfg_next.settle_seconds   = cfg_wdata;
                hbw_pkg::REG_MISS_LIMIT:       cfg_next.miss_limit       = cfg_wdata;
                hbw_pkg::REG_MAIN_OFF_TICKS:   cfg_next.main_off_ticks   = cfg_wdata;
                hbw_pkg::REG_MODULE_OFF_TICKS: cfg_next.module_off_ticks = cfg_wdata;
                default: ;  // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_seconds   <= hbw_pkg::SETTLE_SECONDS_RST;
            cfg_reg.miss_limit       <= hbw_pkg::MISS_LIMIT_RST;
            cfg_reg.main_off_ticks   <= hbw_pkg::MAIN_OFF_TICKS_RST;
            cfg_reg.module_off_ticks <= hbw_pkg::MODULE_OFF_TICKS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/hbw_core.sv =====
// ----------------------------------------------------------------------------
// hbw_core
// watchdog state and restart sequencer, one event per step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heartbeat_watchdog_power_cycler_macros.svh"

module hbw_core
#(
    parameter int LOSS_COUNT_MAX = 10
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic [1:0]         req_type,
    input  logic               supply_failed,
    input  hbw_pkg::cfg_t      cfg,
    output hbw_pkg::result_t   result
);

    hbw_pkg::phase_t phase_reg;
    hbw_pkg::phase_t phase_next;
    logic [7:0]      settle_count_reg;
    logic [7:0]      settle_count_next;
    logic [7:0]      miss_count_reg;
    logic [7:0]      miss_count_next;
    logic [3:0]      loss_count_reg;
    logic [3:0]      loss_count_next;
    logic [7:0]      phase_ticks_reg;
    logic [7:0]      phase_ticks_next;
    logic            pending_reg;
    logic            pending_next;
    logic            level_reg;
    logic            level_next;
    logic            busy;

    localparam logic [3:0] LOSS_MAX = 4'(LOSS_COUNT_MAX);

    assign busy = (phase_reg != hbw_pkg::PH_IDLE);

    always_comb
    begin
        phase_next        = phase_reg;
        settle_count_next = settle_count_reg;
        miss_count_next   = miss_count_reg;
        loss_count_next   = loss_count_reg;
        phase_ticks_next  = phase_ticks_reg;
        pending_next      = pending_reg;
        level_next        = level_reg;

        if (step)
        begin
            case (req_type)
                hbw_pkg::REQ_TICK:
                begin
                    if (busy)
                    begin
                        if (phase_ticks_reg > 8'd1)
                        begin
                            phase_ticks_next = phase_ticks_reg - 8'd1;
                        end
                        else if (phase_reg == hbw_pkg::PH_MAIN_OFF)
                        begin
                            phase_next       = hbw_pkg::PH_MODULE_OFF;
                            phase_ticks_next = cfg.module_off_ticks;
                        end
                        else
                        begin
                            // sequence done: reload, then replay a latched supply change
                            phase_next        = hbw_pkg::PH_IDLE;
                            phase_ticks_next  = 8'd0;
                            settle_count_next = cfg.settle_seconds;
                            miss_count_next   = 8'd0;
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                if (level_reg)
                                begin
                                    settle_count_next = 8'd0;
                                    loss_count_next   = 4'd1;
                                end
                                else
                                begin
                                    loss_count_next = 4'd0;
                                end
                            end
                        end
                    end
                    else
                    begin
                        if (loss_count_reg != 4'd0 && loss_count_reg < LOSS_MAX)
                        begin
                            loss_count_next = loss_count_reg + 4'd1;
                        end
                        if (miss_count_reg > cfg.miss_limit)
                        begin
                            // hang declared; restart only with supply present
                            if (loss_count_reg == 4'd0)
                            begin
                                phase_next       = hbw_pkg::PH_MAIN_OFF;
                                phase_ticks_next = cfg.main_off_ticks;
                            end
                        end
                        else if (settle_count_reg != 8'd0)
                        begin
                            settle_count_next = settle_count_reg - 8'd1;
                        end
                        else
                        begin
                            miss_count_next = miss_count_reg + 8'd1;
                        end
                    end
                end
                hbw_pkg::REQ_HEARTBEAT:
                begin
                    if (!busy)
                    begin
                        miss_count_next = 8'd0;
                    end
                end
                hbw_pkg::REQ_SUPPLY:
                begin
                    if (busy)
                    begin
                        level_next   = supply_failed;
                        pending_next = 1'b1;
                    end
                    else if (supply_failed)
                    begin
                        settle_count_next = 8'd0;
                        loss_count_next   = 4'd1;
                    end
                    else
                    begin
                        loss_count_next = 4'd0;
                    end
                end
                default: ;
            endcase
        end

        result.main_power_on  = (phase_next != hbw_pkg::PH_MAIN_OFF);
        result.module_enable  = (phase_next != hbw_pkg::PH_MODULE_OFF);
        result.restart_active = (phase_next != hbw_pkg::PH_IDLE);
        result.supply_lost    = (loss_count_next != 4'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= hbw_pkg::PH_IDLE;
            settle_count_reg <= hbw_pkg::SETTLE_SECONDS_RST;
            miss_count_reg   <= 8'd0;
            loss_count_reg   <= 4'd0;
            phase_ticks_reg  <= 8'd0;
            pending_reg      <= 1'b0;
            level_reg        <= 1'b0;
        end
        else
        begin
            phase_reg        <= phase_next;
            settle_count_reg <= settle_count_next;
            miss_count_reg   <= miss_count_next;
            loss_count_reg   <= loss_count_next;
            phase_ticks_reg  <= phase_ticks_next;
            pending_reg      <= pending_next;
            level_reg        <= level_next;
        end
    end

    `HBW_ASSERT_NOW(a_loss_bounded, 1'b1, loss_count_reg <= LOSS_MAX, "loss count past its limit")
    `HBW_ASSERT_NOW(a_pending_busy, pending_reg, phase_reg != hbw_pkg::PH_IDLE, "pending supply while idle")
    `HBW_ASSERT_NEXT(a_seq_end, step && req_type == hbw_pkg::REQ_TICK && phase_reg == hbw_pkg::PH_MODULE_OFF && phase_ticks_reg <= 8'd1, phase_reg == hbw_pkg::PH_IDLE && miss_count_reg == 8'd0, "restart did not end cleanly")
    `HBW_ASSERT_NEXT(a_hb_clears, step && req_type == hbw_pkg::REQ_HEARTBEAT && phase_reg == hbw_pkg::PH_IDLE, miss_count_reg == 8'd0, "heartbeat did not clear misses")

endmodule

// ===== sv/heartbeat_watchdog_power_cycler.sv =====
// ----------------------------------------------------------------------------
// heartbeat_watchdog_power_cycler
// heartbeat watchdog that power cycles a hung wireless module
// ----------------------------------------------------------------------------
// Each input transaction is one event (tick, heartbeat edge or supply
// comparator change) and produces exactly one output transaction that
// reports the drive levels after the event. A transaction is taken in every
// cycle unless the input register is full and cannot pass its event on.
// An accepted event is held in the input register and then moves into the
// result register, whose drive levels are computed combinationally from the
// state update in hbw_core. While a result waits, the input register takes
// at most one further event and then the input stalls until the result is
// taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "heartbeat_watchdog_power_cycler_macros.svh"

module heartbeat_watchdog_power_cycler
#(
    parameter int LOSS_COUNT_MAX = 10   // supply loss count saturates here
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    // event stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,   // [0] supply_failed
    input  logic [1:0]                         s_axis_tuser,   // [1:0] req_type

    // drive level stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] main_power_on, [1] module_enable, [2] restart_active, [3] supply_lost
    output logic [7:0]                         m_axis_tdata,

    // configuration writes
    input  logic                               cfg_we,
    input  logic [hbw_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [hbw_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    // input stage
    logic              in_valid_reg;
    logic              in_valid_next;
    logic [1:0]        in_type_reg;
    logic              in_failed_reg;

    // result stage
    logic              out_valid_reg;
    logic              out_valid_next;
    hbw_pkg::result_t  out_result_reg;

    hbw_pkg::cfg_t     cfg;
    hbw_pkg::result_t  core_result;
    logic              s_accept;
    logic              advance;

    // event moves into the core when the result register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (advance)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_type_reg   <= s_axis_tuser;
            in_failed_reg <= s_axis_tdata[0];
        end
        if (advance)
        begin
            out_result_reg <= core_result;
        end
    end

    hbw_cfg_regs u_cfg_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    hbw_core
    #(
        .LOSS_COUNT_MAX (LOSS_COUNT_MAX)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .req_type      (in_type_reg),
        .supply_failed (in_failed_reg),
        .cfg           (cfg),
        .result        (core_result)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'd0,
                            out_result_reg.supply_lost,
                            out_result_reg.restart_active,
                            out_result_reg.module_enable,
                            out_result_reg.main_power_on};

    `HBW_ASSERT_NOW(a_no_bubble, in_valid_reg && !out_valid_reg, advance, "input stage stalled with empty result stage")
    `HBW_ASSERT_NEXT(a_result_from_event, advance, out_valid_reg, "stepped event produced no result")
    `HBW_ASSERT_NOW(a_ready_when_empty, !in_valid_reg, s_axis_tready, "empty input stage not ready")

endmodule
